[sv/doppler_fft_peak_detector_defines.svh]
// Assertion macros of the Doppler FFT peak detector, used by the sequencer.
`ifndef DOPPLER_FFT_PEAK_DETECTOR_DEFINES_SVH
`define DOPPLER_FFT_PEAK_DETECTOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DFPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfpd: assertion failed");

// Check that cons holds in the cycle after ante.
`define DFPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfpd: assertion failed");

`endif

[sv/dfpd_pkg.sv]
// Shared types, constants and the twiddle table generator of the Doppler peak detector.
package dfpd_pkg;

  localparam int MAX_FFT_POINTS_DEF = 256;
  localparam int RANGE_BINS_DEF     = 2048;
  localparam logic [3:0] FFT_LOG2_RESET = 4'd3;
  localparam int FFT_LOG2_MIN       = 2;
  localparam longint unsigned PI_Q28 = 64'd843314856;

  // Datapath operations commanded by the controller states
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_STORE,
    OP_LOAD_RD,
    OP_LOAD_WR,
    OP_BF_RD,
    OP_BF_MUL,
    OP_BF_SUM,
    OP_BF_WR_I,
    OP_BF_WR_P,
    OP_PW_RD,
    OP_PW_MUL,
    OP_PW_CMP,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WR_I,
    ST_BF_WR_P,
    ST_PW_RD,
    ST_PW_MUL,
    ST_PW_CMP,
    ST_SQ_INIT,
    ST_SQ_STEP,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;    // last history address in the clearing pass
    logic fft_due;     // the current pulse is a transform pulse
    logic load_last;   // index at the last point
    logic bf_last;     // index at the last butterfly of a stage
    logic stage_last;  // stage counter at the last stage
    logic sqrt_last;   // last root step
    logic out_free;    // output register can take a result
  } dp_stat_t;

  // Q1.15 cosine of 2*pi*k/2^lg_m, from a fixed-point Taylor series
  function automatic logic [16:0] cos_q15(input int unsigned k, input int unsigned lg_m);
    longint unsigned th;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    int unsigned     n;
    th   = (64'd2 * PI_Q28 * k) >> lg_m;
    x2   = (th * th) >> 28;
    sum  = 64'sd1 <<< 28;
    term = 64'd1 << 28;
    for (n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 28) / 64'((2 * n - 1) * (2 * n));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 17'((sum + 4096) >>> 13);
  endfunction

endpackage

[sv/dfpd_ctrl.sv]
// Sequencer of the Doppler peak detector: clear, store, load, butterflies, peak search, root, output.
`include "doppler_fft_peak_detector_defines.svh"
module dfpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  dfpd_pkg::dp_stat_t stat,
  output dfpd_pkg::dp_cmd_t  cmd
);
  import dfpd_pkg::*;

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = OP_STORE;
          if (stat.fft_due) state_next = ST_LOAD_RD;
        end
      end
      ST_LOAD_RD: begin
        cmd.op     = OP_LOAD_RD;
        state_next = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        cmd.op     = OP_LOAD_WR;
        state_next = stat.load_last ? ST_BF_RD : ST_LOAD_RD;
      end
      ST_BF_RD: begin
        cmd.op     = OP_BF_RD;
        state_next = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd.op     = OP_BF_MUL;
        state_next = ST_BF_SUM;
      end
      ST_BF_SUM: begin
        cmd.op     = OP_BF_SUM;
        state_next = ST_BF_WR_I;
      end
      ST_BF_WR_I: begin
        cmd.op     = OP_BF_WR_I;
        state_next = ST_BF_WR_P;
      end
      ST_BF_WR_P: begin
        cmd.op     = OP_BF_WR_P;
        state_next = (stat.bf_last && stat.stage_last) ? ST_PW_RD : ST_BF_RD;
      end
      ST_PW_RD: begin
        cmd.op     = OP_PW_RD;
        state_next = ST_PW_MUL;
      end
      ST_PW_MUL: begin
        cmd.op     = OP_PW_MUL;
        state_next = ST_PW_CMP;
      end
      ST_PW_CMP: begin
        cmd.op     = OP_PW_CMP;
        state_next = stat.load_last ? ST_SQ_INIT : ST_PW_RD;
      end
      ST_SQ_INIT: begin
        cmd.op     = OP_SQ_INIT;
        state_next = ST_SQ_STEP;
      end
      ST_SQ_STEP: begin
        cmd.op = OP_SQ_STEP;
        if (stat.sqrt_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `DFPD_ASSERT_NEXT(a_fft_start, clk, rst, state == ST_IDLE && s_tvalid && stat.fft_due, state == ST_LOAD_RD)
  `DFPD_ASSERT_NEXT(a_out_hold, clk, rst, state == ST_OUT && !stat.out_free, state == ST_OUT)
  `DFPD_ASSERT_NEXT(a_bf_done, clk, rst, state == ST_BF_WR_P && stat.bf_last && stat.stage_last, state == ST_PW_RD)

endmodule

[sv/dfpd_datapath.sv]
// Datapath: pulse history memory, transform work memory, butterfly, power search and root.
module dfpd_datapath #(
  parameter int MAX_FFT_POINTS = dfpd_pkg::MAX_FFT_POINTS_DEF,
  parameter int RANGE_BINS     = dfpd_pkg::RANGE_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dfpd_pkg::dp_cmd_t  cmd,
  output dfpd_pkg::dp_stat_t stat,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  logic [7:0]         i_sample,
  input  logic [7:0]         q_sample,
  input  logic               last_in_pulse,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         amplitude,
  output logic [3:0]         doppler_bin,
  output logic [10:0]        range_bin,
  output logic               last_of_pulse
);
  import dfpd_pkg::*;

  localparam int SW  = $clog2(MAX_FFT_POINTS);
  localparam int RW  = $clog2(RANGE_BINS);
  localparam int HA  = SW + RW;
  localparam int HD  = 1 << HA;
  localparam int W   = SW + 25;
  localparam int QR  = MAX_FFT_POINTS / 4;
  localparam int STW = $clog2(SW + 1);
  localparam int PW  = W + 18;

  // Configuration and pulse bookkeeping
  logic [3:0]    fft_log2;
  logic [3:0]    eff_lg;
  logic [SW-1:0] pulse_slot;
  logic [RW-1:0] range_cnt;
  logic [SW-2:0] dec_cnt;
  logic [HA-1:0] clr_addr;

  // Item held for the transform
  logic [SW-1:0] cur_slot;
  logic [RW-1:0] cur_rbin;
  logic          cur_last;
  logic [3:0]    cur_lg;

  // Transform sequencing
  logic [SW-1:0]  k;
  logic [STW-1:0] st;
  logic [SW:0]    n_pts;
  logic [SW-1:0]  nmask;

  // Memories
  logic [15:0]      hist [HD];
  logic [15:0]      hist_q;
  logic             hist_we;
  logic [HA-1:0]    hist_wa;
  logic [15:0]      hist_wd;
  logic [2*W-1:0]   work [MAX_FFT_POINTS];
  logic             wk_we, wk_re;
  logic [SW-1:0]    wk_wa, wk_ra, wk_rb;
  logic [2*W-1:0]   wk_wd;
  logic [2*W-1:0]   xa, xb;

  logic [SW-1:0] rev_full, rev, rd_slot;
  logic [SW-1:0] lowmask, bi, bp, jj, tk;
  logic [SW-2:0] tki;
  logic [16:0]   cos_tab [QR+1];
  logic signed [17:0] tw_c, tw_s, c_r, s_r;
  logic [SW-1:0] bi_r, bp_r;

  logic signed [W-1:0]  xa_re, xa_im, xb_re, xb_im;
  logic signed [PW-1:0] pr1, pr2, pr3, pr4;
  logic signed [PW:0]   sum1, sum2;
  logic signed [W-1:0]  t1, t2;
  logic [2*W-1:0]       y_i, y_p;

  logic [2*W-1:0] sq_re, sq_im, pw, best, best_sh;
  logic [SW-1:0]  bidx;
  logic [5:0]     shamt;
  logic [16:0]    rem, root, sbit, trial;
  logic           sat_r;
  logic [SW+3:0]  dsh;

  logic [SW-1:0] dec_inc, quarter;
  logic [RW:0]   rng_inc;
  logic          accept;

  assign accept = (cmd.op == OP_STORE);

  // Clamp the transform length register
  always_comb begin
    if (fft_log2 < 4'(FFT_LOG2_MIN)) begin
      eff_lg = 4'(FFT_LOG2_MIN);
    end else if (fft_log2 > 4'(SW)) begin
      eff_lg = 4'(SW);
    end else begin
      eff_lg = fft_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fft_log2 <= FFT_LOG2_RESET;
    end else if (cfg_we) begin
      fft_log2 <= cfg_wdata;
    end
  end

  // Pulse counters
  assign dec_inc = {1'b0, dec_cnt} + SW'(1);
  assign quarter = SW'(1) << (eff_lg - 4'd2);
  assign rng_inc = {1'b0, range_cnt} + (RW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_slot <= '0;
      range_cnt  <= '0;
      dec_cnt    <= '0;
      clr_addr   <= '0;
    end else begin
      if (cmd.op == OP_CLEAR) clr_addr <= clr_addr + HA'(1);
      if (accept) begin
        if (last_in_pulse) begin
          range_cnt  <= '0;
          pulse_slot <= pulse_slot + SW'(1);
          dec_cnt    <= (dec_inc >= quarter) ? '0 : dec_inc[SW-2:0];
        end else if (rng_inc >= (RW+1)'(RANGE_BINS)) begin
          range_cnt <= '0;
        end else begin
          range_cnt <= rng_inc[RW-1:0];
        end
      end
    end
  end

  // Latch the item for its transform
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_slot <= pulse_slot;
      cur_rbin <= range_cnt;
      cur_last <= last_in_pulse;
      cur_lg   <= eff_lg;
    end
  end

  assign n_pts = (SW+1)'(1) << cur_lg;
  assign nmask = SW'(n_pts - (SW+1)'(1));

  // Point and stage counters
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_STORE: begin
        k  <= '0;
        st <= '0;
      end
      OP_LOAD_WR: begin
        k <= (k == nmask) ? '0 : k + SW'(1);
      end
      OP_BF_WR_P: begin
        if (k == (nmask >> 1)) begin
          k  <= '0;
          st <= st + STW'(1);
        end else begin
          k <= k + SW'(1);
        end
      end
      OP_PW_CMP: begin
        k <= k + SW'(1);
      end
      default: begin
      end
    endcase
  end

  // History read address: slot of the pulse bit-reversed back from the current one
  always_comb begin
    for (int b = 0; b < SW; b++) begin
      rev_full[b] = k[SW-1-b];
    end
    rev     = rev_full >> (4'(SW) - cur_lg);
    rd_slot = cur_slot - rev;
  end

  always_comb begin
    hist_we = (cmd.op == OP_CLEAR) || accept;
    hist_wa = (cmd.op == OP_CLEAR) ? clr_addr : {pulse_slot, range_cnt};
    hist_wd = (cmd.op == OP_CLEAR) ? 16'd0 : {i_sample, q_sample};
  end

  // Pulse history memory
  always_ff @(posedge clk) begin
    if (hist_we) hist[hist_wa] <= hist_wd;
    if (cmd.op == OP_LOAD_RD) hist_q <= hist[{rd_slot, cur_rbin}];
  end

  // Butterfly addresses and twiddle index
  always_comb begin
    lowmask = (SW'(1) << st) - SW'(1);
    bi      = ((k & ~lowmask) << 1) | (k & lowmask);
    bp      = bi | (SW'(1) << st);
    jj      = k & lowmask;
    tk      = jj << (SW - 1 - int'(st));
    tki     = tk[SW-2:0];
  end

  // Quarter-wave cosine table
  for (genvar g = 0; g <= QR; g++) begin : g_cos
    assign cos_tab[g] = cos_q15(g, SW);
  end

  always_comb begin
    logic [SW-1:0] mirror;
    mirror = SW'(2 * QR) - {1'b0, tki};
    if (tki <= (SW-1)'(QR)) begin
      tw_c = $signed({1'b0, cos_tab[tki]});
      tw_s = $signed({1'b0, cos_tab[(SW-1)'(QR) - tki]});
    end else begin
      tw_c = -$signed({1'b0, cos_tab[mirror[SW-2:0]]});
      tw_s = $signed({1'b0, cos_tab[tki - (SW-1)'(QR)]});
    end
  end

  // Work memory port selection
  always_comb begin
    wk_re = (cmd.op == OP_BF_RD) || (cmd.op == OP_PW_RD);
    wk_ra = (cmd.op == OP_PW_RD) ? k : bi;
    wk_rb = bp;
    wk_we = 1'b0;
    wk_wa = k;
    wk_wd = {{(W-23){hist_q[15]}}, hist_q[15:8], 15'd0,
             {(W-23){hist_q[7]}}, hist_q[7:0], 15'd0};
    case (cmd.op)
      OP_LOAD_WR: wk_we = 1'b1;
      OP_BF_WR_I: begin
        wk_we = 1'b1;
        wk_wa = bi_r;
        wk_wd = y_i;
      end
      OP_BF_WR_P: begin
        wk_we = 1'b1;
        wk_wa = bp_r;
        wk_wd = y_p;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wk_we) work[wk_wa] <= wk_wd;
    if (wk_re) begin
      xa <= work[wk_ra];
      xb <= work[wk_rb];
    end
  end

  assign xa_re = $signed(xa[2*W-1:W]);
  assign xa_im = $signed(xa[W-1:0]);
  assign xb_re = $signed(xb[2*W-1:W]);
  assign xb_im = $signed(xb[W-1:0]);

  // Rotate with rounding to Q15, then add and subtract
  always_comb begin
    sum1 = (PW+1)'(pr1) + (PW+1)'(pr2) + (PW+1)'(16384);
    sum2 = (PW+1)'(pr3) - (PW+1)'(pr4) + (PW+1)'(16384);
    t1   = W'(sum1 >>> 15);
    t2   = W'(sum2 >>> 15);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_BF_RD: begin
        bi_r <= bi;
        bp_r <= bp;
        c_r  <= tw_c;
        s_r  <= tw_s;
      end
      OP_BF_MUL: begin
        pr1 <= PW'(xb_re) * PW'(c_r);
        pr2 <= PW'(xb_im) * PW'(s_r);
        pr3 <= PW'(xb_im) * PW'(c_r);
        pr4 <= PW'(xb_re) * PW'(s_r);
      end
      OP_BF_SUM: begin
        y_i <= {xa_re + t1, xa_im + t2};
        y_p <= {xa_re - t1, xa_im - t2};
      end
      default: begin
      end
    endcase
  end

  // Power of each bin and running peak
  assign pw = sq_re + sq_im;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_STORE: begin
        best <= '0;
        bidx <= '0;
      end
      OP_PW_MUL: begin
        sq_re <= (2*W)'(xa_re) * (2*W)'(xa_re);
        sq_im <= (2*W)'(xa_im) * (2*W)'(xa_im);
      end
      OP_PW_CMP: begin
        if (pw > best) begin
          best <= pw;
          bidx <= k;
        end
      end
      default: begin
      end
    endcase
  end

  // Scale by 1/N^3 and 2^-30, then integer root two bits a step
  assign shamt   = 6'(3 * cur_lg) + 6'd30;
  assign best_sh = best >> shamt;
  assign trial   = root + sbit;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SQ_INIT: begin
        rem   <= {1'b0, best_sh[15:0]};
        root  <= '0;
        sbit  <= 17'h4000;
        sat_r <= |best_sh[2*W-1:16];
      end
      OP_SQ_STEP: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
      end
      default: begin
      end
    endcase
  end

  // Output register
  assign dsh = {bidx, 4'd0} >> cur_lg;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      amplitude     <= sat_r ? 8'd255 : root[7:0];
      doppler_bin   <= dsh[3:0];
      range_bin     <= 11'(cur_rbin);
      last_of_pulse <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Status to the sequencer
  always_comb begin
    stat.clr_last   = &clr_addr;
    stat.fft_due    = (dec_cnt == '0);
    stat.load_last  = (k == nmask);
    stat.bf_last    = (k == (nmask >> 1));
    stat.stage_last = (st == STW'(cur_lg - 4'd1));
    stat.sqrt_last  = sbit[0];
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

[sv/doppler_fft_peak_detector.sv]
// Top level of the Doppler FFT peak detector: stream ports, sequencer and datapath.
// One transfer in is one range bin of a pulse. Every pulse is written to a history of the
// last MAX_FFT_POINTS pulses; on every N/4-th pulse (N = 2^fft_log2, clamped to 4..
// MAX_FFT_POINTS) each bin also runs an N-point transform across pulses and gives one
// result. A sample of any other pulse is only written to the history. A transform sample
// runs the history loads, the butterflies (through one shared rotate unit and the single
// write port of the work memory), the power search, the root and the output in that order,
// and input is held off until it is done. After reset a clearing pass writes zero to every
// one of the MAX_FFT_POINTS * 2^ceil(log2(RANGE_BINS)) history words (524288 by default),
// one per cycle, and input is held off until it ends. A finished result waits in the output
// register while the next sample is taken in.
module doppler_fft_peak_detector #(
  parameter int MAX_FFT_POINTS = dfpd_pkg::MAX_FFT_POINTS_DEF,
  parameter int RANGE_BINS     = dfpd_pkg::RANGE_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // i_sample [7:0], q_sample [15:8]
  input  logic        s_tlast,   // last_in_pulse
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // amplitude [7:0], doppler_bin [11:8], range_bin [22:12]
  output logic        m_tlast,   // last_of_pulse
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata  // fft_log2
);
  import dfpd_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [7:0]  amplitude;
  logic [3:0]  doppler_bin;
  logic [10:0] range_bin;

  dfpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dfpd_datapath #(
    .MAX_FFT_POINTS (MAX_FFT_POINTS),
    .RANGE_BINS     (RANGE_BINS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .i_sample      (s_tdata[7:0]),
    .q_sample      (s_tdata[15:8]),
    .last_in_pulse (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .amplitude     (amplitude),
    .doppler_bin   (doppler_bin),
    .range_bin     (range_bin),
    .last_of_pulse (m_tlast)
  );

  // Pack the result fields
  assign m_tdata = {1'b0, range_bin, doppler_bin, amplitude};

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the Doppler FFT peak detector: directed table, then random pulses.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_SLOTS = 256;
  localparam int RANGE_LEN  = 2048;
  localparam int STALL_LIMIT = 1600000;  // clearing pass after reset dominates
  localparam int ITEMS_PER_PHASE = 64;

  typedef struct {
    logic [7:0]  amp;
    logic [3:0]  dbin;
    logic [10:0] rng;
    logic        lst;
  } peak_t;

  typedef struct {
    logic [7:0] i_val;
    logic [7:0] q_val;
    logic       lst;
    bit         typed;
    peak_t      want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;

  // predictor state
  bit   [15:0] hist_mem [HIST_SLOTS * RANGE_LEN];
  int unsigned slot_now;
  int unsigned range_now;
  int unsigned dec_now;
  logic [3:0]  log2_reg;
  longint      cos_tab [HIST_SLOTS / 4 + 1];
  peak_t       peak_q [$];

  int  errors;
  int  results_seen;
  int  items_sent;
  int  idle_cycles;
  bit  steady;
  row_t dir_rows [$];

  doppler_fft_peak_detector dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Q1.15 cosine quarter table from a fixed-point Taylor series
  function automatic void build_cos();
    longint unsigned th, x2, term;
    longint sum;
    for (int k = 0; k <= HIST_SLOTS / 4; k++) begin
      th   = (64'd2 * 64'd843314856 * longint'(k)) / HIST_SLOTS;
      x2   = (th * th) >> 28;
      sum  = 64'sd1 <<< 28;
      term = 64'd1 << 28;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 28) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      cos_tab[k] = (sum + 4096) >>> 13;
    end
  endfunction

  function automatic longint rnd15(longint v);
    longint w;
    w = v + 16384;
    if (w >= 0) begin
      return w >>> 15;
    end
    return -longint'((longint'(-w) + 32767) >>> 15);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int unsigned eff_log2();
    if (log2_reg < 2) return 2;
    if (log2_reg > 8) return 8;
    return log2_reg;
  endfunction

  // Transform across the newest pulses of one range bin and pick the strongest bin
  function automatic peak_t doppler_peak(int unsigned lg, int unsigned rbin);
    longint re [HIST_SLOTS];
    longint im [HIST_SLOTS];
    int unsigned npts, rev, t, slot, half, stp, tw, p, best_bin;
    longint c, s, t1, t2;
    longint unsigned a, b, pw, best, amp;
    logic [15:0] word;
    peak_t res;
    npts = 1 << lg;
    for (int unsigned k = 0; k < npts; k++) begin
      rev = 0;
      t = k;
      for (int unsigned bb = 0; bb < lg; bb++) begin
        rev = (rev << 1) | (t & 1);
        t = t >> 1;
      end
      slot = (slot_now + HIST_SLOTS - (rev % HIST_SLOTS)) % HIST_SLOTS;
      word = hist_mem[slot * RANGE_LEN + rbin];
      re[k] = longint'($signed(word[15:8])) * 32768;
      im[k] = longint'($signed(word[7:0])) * 32768;
    end
    half = 1;
    while (half < npts) begin
      stp = HIST_SLOTS / (2 * half);
      for (int unsigned j = 0; j < half; j++) begin
        tw = j * stp;
        if (tw <= HIST_SLOTS / 4) begin
          c = cos_tab[tw];
          s = cos_tab[HIST_SLOTS / 4 - tw];
        end else begin
          c = -cos_tab[HIST_SLOTS / 2 - tw];
          s = cos_tab[tw - HIST_SLOTS / 4];
        end
        for (int unsigned i = j; i < npts; i += 2 * half) begin
          p = i + half;
          t1 = rnd15(c * re[p] + s * im[p]);
          t2 = rnd15(c * im[p] - s * re[p]);
          re[p] = re[i] - t1;
          im[p] = im[i] - t2;
          re[i] = re[i] + t1;
          im[i] = im[i] + t2;
        end
      end
      half = half << 1;
    end
    best = 0;
    best_bin = 0;
    for (int unsigned k = 0; k < npts; k++) begin
      a = (re[k] < 0) ? longint'(-re[k]) : re[k];
      b = (im[k] < 0) ? longint'(-im[k]) : im[k];
      pw = a * a + b * b;
      if (pw > best) begin
        best = pw;
        best_bin = k;
      end
    end
    amp = int_sqrt(best >> (3 * lg + 30));
    if (amp > 255) begin
      amp = 255;
    end
    res.amp  = amp[7:0];
    res.dbin = 4'((best_bin * 16) >> lg);
    res.rng  = 11'(rbin);
    res.lst  = 1'b0;
    return res;
  endfunction

  // Store the sample, queue a result on transform pulses, advance counters
  function automatic void predict_sample(logic [7:0] iv, logic [7:0] qv, logic lst,
                                         bit typed, peak_t want);
    int unsigned lg, quarter;
    peak_t pk;
    lg = eff_log2();
    quarter = (1 << lg) / 4;
    hist_mem[slot_now * RANGE_LEN + range_now] = {iv, qv};
    if (dec_now == 0) begin
      pk = doppler_peak(lg, range_now);
      pk.lst = lst;
      peak_q.push_back(typed ? want : pk);
    end
    if (lst) begin
      range_now = 0;
      slot_now = (slot_now + 1) % HIST_SLOTS;
      dec_now = (dec_now + 1 >= quarter) ? 0 : dec_now + 1;
    end else begin
      range_now = (range_now + 1) % RANGE_LEN;
    end
  endfunction

  // Offer one transfer, hold it until taken, then predict
  task automatic send_sample(logic [7:0] iv, logic [7:0] qv, logic lst, bit typed,
                             peak_t want);
    while (!steady && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {qv, iv};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_sample(iv, qv, lst, typed, want);
  endtask

  // Drain all results, let the block settle, then write the register
  task automatic write_log2(logic [3:0] val);
    s_tvalid <= 1'b0;
    while (peak_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    log2_reg = val;
  endtask

  function automatic logic [7:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'h80;
    if (pick == 1) return 8'h7f;
    return 8'($urandom);
  endfunction

  // Check results against the oldest expectation; watch for stalls
  always @(posedge clk) begin
    peak_t exp_pk;
    if (m_tvalid && m_tready) begin
      results_seen++;
      if (peak_q.size() == 0) begin
        errors++;
        $display("%0t: expected no result, actual tdata=%h tlast=%b", $time, m_tdata,
                 m_tlast);
      end else begin
        exp_pk = peak_q.pop_front();
        if (m_tdata[7:0] !== exp_pk.amp) begin
          errors++;
          $display("%0t: amplitude expected %0d actual %0d", $time, exp_pk.amp,
                   m_tdata[7:0]);
        end
        if (m_tdata[11:8] !== exp_pk.dbin) begin
          errors++;
          $display("%0t: doppler bin expected %0d actual %0d", $time, exp_pk.dbin,
                   m_tdata[11:8]);
        end
        if (m_tdata[22:12] !== exp_pk.rng) begin
          errors++;
          $display("%0t: range bin expected %0d actual %0d", $time, exp_pk.rng,
                   m_tdata[22:12]);
        end
        if (m_tlast !== exp_pk.lst) begin
          errors++;
          $display("%0t: tlast expected %b actual %b", $time, exp_pk.lst, m_tlast);
        end
      end
    end
    if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
    m_tready <= rst ? 1'b0 : (steady || $urandom_range(99) >= 17);
  end

  function automatic row_t mk_row(logic [7:0] iv, logic [7:0] qv, logic lst, bit typed,
                                  logic [7:0] amp, logic [10:0] rng);
    row_t r;
    r.i_val = iv;
    r.q_val = qv;
    r.lst = lst;
    r.typed = typed;
    r.want.amp = amp;
    r.want.dbin = 4'd0;
    r.want.rng = rng;
    r.want.lst = lst;
    return r;
  endfunction

  initial begin
    logic [3:0] phase_cfg [9] = '{4'd0, 4'd15, 4'd2, 4'd5, 4'd3, 4'd8, 4'd6, 4'd4, 4'd1};
    int unsigned max_len, plen, cnt;
    peak_t none;
    row_t r;
    none = '{default: '0};
    items_sent = 0;
    steady = 1'b0;
    slot_now = 0;
    range_now = 0;
    dec_now = 0;
    log2_reg = 4'd3;
    build_cos();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 4'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at reset setting (8 points, every second pulse transforms).
    // First pulse sees an empty history: flat spectrum, bin 0 wins.
    dir_rows.push_back(mk_row(8'h00, 8'h00, 1'b0, 1'b1, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h80, 8'h80, 1'b0, 1'b1, 8'd8, 11'd1));
    dir_rows.push_back(mk_row(8'h7f, 8'h7f, 1'b0, 1'b1, 8'd7, 11'd2));
    dir_rows.push_back(mk_row(8'h7f, 8'h80, 1'b1, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h05, 8'hfd, 1'b0, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'hff, 8'h01, 1'b0, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h7f, 8'h7f, 1'b0, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h40, 8'hc0, 1'b1, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h80, 8'h7f, 1'b0, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h01, 8'h02, 1'b0, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h80, 8'h80, 1'b0, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h55, 8'haa, 1'b1, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h80, 8'h00, 1'b0, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h00, 8'h7f, 1'b1, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h7f, 8'h00, 1'b0, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h00, 8'h80, 1'b0, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'hc3, 8'h3c, 1'b1, 1'b0, 8'd0, 11'd0));
    dir_rows.push_back(mk_row(8'h80, 8'h80, 1'b1, 1'b0, 8'd0, 11'd0));
    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      send_sample(r.i_val, r.q_val, r.lst, r.typed, r.want);
    end

    // Random pulses across settings; one phase without idling
    foreach (phase_cfg[ph]) begin
      write_log2(phase_cfg[ph]);
      steady = (ph == 4);
      max_len = (eff_log2() <= 5) ? 8 : (eff_log2() == 6 ? 3 : 1);
      cnt = 0;
      while (cnt < ITEMS_PER_PHASE) begin
        plen = $urandom_range(max_len, 1);
        for (int unsigned k = 0; k < plen; k++) begin
          send_sample(rand_sample(), rand_sample(), k == plen - 1, 1'b0, none);
          cnt++;
        end
      end
    end
    steady = 1'b0;
    write_log2(4'd3);
    send_sample(8'h12, 8'h34, 1'b1, 1'b0, none);

    s_tvalid <= 1'b0;
    while (peak_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d samples and %0d peak results over nine length settings,",
             items_sent, results_seen);
    $display("including clamped lengths, register changes and an idle-free stretch");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
